// ===== design/lkc_pkg.sv =====
package lkc_pkg;

	localparam int DEF_ENTRIES      = 48;
	localparam int DEF_KEY_BITS     = 64;
	localparam int DEF_PAYLOAD_BITS = 32;

	localparam int KEY_TAG_W  = 64;
	localparam int IN_PAY_W   = 32;
	localparam int SLOT_W     = 6;
	localparam int OUT_PAY_W  = 32;
	localparam int STAMP_W    = 64;

	localparam logic MODE_ACCESS = 1'b0;
	localparam logic MODE_FLUSH  = 1'b1;

	typedef struct packed {
		logic                 mode;
		logic [KEY_TAG_W-1:0] key_tag;
		logic [IN_PAY_W-1:0]  fill_payload;
	} cmd_t;

	typedef struct packed {
		logic                 hit;
		logic [SLOT_W-1:0]    slot_index;
		logic [OUT_PAY_W-1:0] payload_out;
		logic                 evicted;
		logic [OUT_PAY_W-1:0] evicted_payload;
	} rsp_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

// ===== design/lkc_table.sv =====
module lkc_table #(
	parameter int ENTRIES = lkc_pkg::DEF_ENTRIES,
	parameter int KEY_W   = lkc_pkg::DEF_KEY_BITS,
	parameter int PAY_W   = lkc_pkg::DEF_PAYLOAD_BITS,
	parameter int IDX_W   = $clog2(ENTRIES)
) (
	input  logic                        clk,
	input  logic [IDX_W-1:0]            rd_addr,
	input  logic                        wr_en,
	input  logic [IDX_W-1:0]            wr_addr,
	input  logic [KEY_W-1:0]            wr_key,
	input  logic [PAY_W-1:0]            wr_pay,
	input  logic [lkc_pkg::STAMP_W-1:0] wr_stamp,
	output logic [KEY_W-1:0]            rd_key_s1,
	output logic [PAY_W-1:0]            rd_pay_s1,
	output logic [lkc_pkg::STAMP_W-1:0] rd_stamp_s1
);

	logic [KEY_W-1:0]            key_mem   [ENTRIES];
	logic [PAY_W-1:0]            pay_mem   [ENTRIES];
	logic [lkc_pkg::STAMP_W-1:0] stamp_mem [ENTRIES];

	// one write port, one registered read port shared by all three fields
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr]   <= wr_key;
			pay_mem[wr_addr]   <= wr_pay;
			stamp_mem[wr_addr] <= wr_stamp;
		end
		rd_key_s1   <= key_mem[rd_addr];
		rd_pay_s1   <= pay_mem[rd_addr];
		rd_stamp_s1 <= stamp_mem[rd_addr];
	end

endmodule

// ===== design/lkc_scan.sv =====
module lkc_scan #(
	parameter int KEY_W = lkc_pkg::DEF_KEY_BITS,
	parameter int PAY_W = lkc_pkg::DEF_PAYLOAD_BITS,
	parameter int IDX_W = 6
) (
	input  logic                        clk,
	input  logic                        valid_s1,
	input  logic [IDX_W-1:0]            idx_s1,
	input  logic [KEY_W-1:0]            key_ref,
	input  logic [KEY_W-1:0]            rd_key_s1,
	input  logic [PAY_W-1:0]            rd_pay_s1,
	input  logic [lkc_pkg::STAMP_W-1:0] rd_stamp_s1,
	output logic                        match,
	output logic [IDX_W-1:0]            victim_idx,
	output logic [PAY_W-1:0]            victim_pay
);

	logic [lkc_pkg::STAMP_W-1:0] min_stamp_q;
	logic [IDX_W-1:0]            min_idx_q;
	logic [PAY_W-1:0]            min_pay_q;
	logic                        take_cur;

	assign match = (rd_key_s1 == key_ref);

	// entry zero restarts the running minimum; strict less keeps the lowest index
	assign take_cur   = (idx_s1 == '0) || (rd_stamp_s1 < min_stamp_q);
	assign victim_idx = take_cur ? idx_s1    : min_idx_q;
	assign victim_pay = take_cur ? rd_pay_s1 : min_pay_q;

	always_ff @(posedge clk) begin
		if (valid_s1 && take_cur) begin
			min_stamp_q <= rd_stamp_s1;
			min_idx_q   <= idx_s1;
			min_pay_q   <= rd_pay_s1;
		end
	end

endmodule

// ===== design/lkc_seq.sv =====
module lkc_seq #(
	parameter int ENTRIES  = lkc_pkg::DEF_ENTRIES,
	parameter int KEY_BITS = lkc_pkg::DEF_KEY_BITS,
	parameter int PAY_W    = lkc_pkg::DEF_PAYLOAD_BITS,
	parameter int IDX_W    = $clog2(ENTRIES),
	parameter int CNT_W    = $clog2(ENTRIES + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  lkc_pkg::cmd_t               cmd,
	output logic                        done,
	output lkc_pkg::rsp_t               result,
	output logic [IDX_W-1:0]            rd_addr,
	output logic                        wr_en,
	output logic [IDX_W-1:0]            wr_addr,
	output logic [KEY_BITS-1:0]         wr_key,
	output logic [PAY_W-1:0]            wr_pay,
	output logic [lkc_pkg::STAMP_W-1:0] wr_stamp,
	output logic                        valid_s1,
	output logic [IDX_W-1:0]            idx_s1,
	output logic [KEY_BITS-1:0]         key_q,
	input  logic [PAY_W-1:0]            rd_pay_s1,
	input  logic                        match,
	input  logic [IDX_W-1:0]            victim_idx,
	input  logic [PAY_W-1:0]            victim_pay
);

	lkc_pkg::state_t             state_q, state_d;
	logic [CNT_W-1:0]            fill_q, fill_d;
	logic [CNT_W-1:0]            rd_cnt_q;
	logic [lkc_pkg::STAMP_W-1:0] use_clock_q, use_clock_d;
	logic                        last_s1;
	logic [PAY_W-1:0]            pay_q;
	logic                        accept, issue, decide, full;
	logic [KEY_BITS-1:0]         in_key;
	logic [PAY_W-1:0]            in_pay;
	logic                        done_d;
	lkc_pkg::rsp_t               rsp_d;
	logic [IDX_W-1:0]            miss_slot;

	assign busy    = (state_q != lkc_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign in_key  = cmd.key_tag[KEY_BITS-1:0];
	assign in_pay  = cmd.fill_payload[PAY_W-1:0];
	assign issue   = (state_q == lkc_pkg::ST_SCAN) && (rd_cnt_q < fill_q);
	assign rd_addr = rd_cnt_q[IDX_W-1:0];
	assign decide  = (state_q == lkc_pkg::ST_SCAN) && valid_s1 && (match || last_s1);
	assign full    = (fill_q == CNT_W'(ENTRIES));
	assign miss_slot = full ? victim_idx : fill_q[IDX_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lkc_pkg::ST_IDLE: begin
				if (accept && cmd.mode == lkc_pkg::MODE_ACCESS && fill_q != '0) begin
					state_d = lkc_pkg::ST_SCAN;
				end
			end
			lkc_pkg::ST_SCAN: begin
				if (decide) begin
					state_d = lkc_pkg::ST_IDLE;
				end
			end
			default: state_d = lkc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		wr_en       = 1'b0;
		wr_addr     = miss_slot;
		wr_key      = key_q;
		wr_pay      = pay_q;
		wr_stamp    = use_clock_q + lkc_pkg::STAMP_W'(1);
		fill_d      = fill_q;
		use_clock_d = use_clock_q;
		done_d      = 1'b0;
		rsp_d       = '0;
		unique case (state_q)
			lkc_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd.mode == lkc_pkg::MODE_FLUSH) begin
						fill_d = '0;
						done_d = 1'b1;
					end else if (fill_q == '0) begin
						// empty table: install in entry zero right away
						wr_en             = 1'b1;
						wr_addr           = '0;
						wr_key            = in_key;
						wr_pay            = in_pay;
						fill_d            = CNT_W'(1);
						use_clock_d       = wr_stamp;
						done_d            = 1'b1;
						rsp_d.payload_out = lkc_pkg::OUT_PAY_W'(in_pay);
					end
				end
			end
			lkc_pkg::ST_SCAN: begin
				if (decide) begin
					wr_en       = 1'b1;
					use_clock_d = wr_stamp;
					done_d      = 1'b1;
					if (match) begin
						wr_addr           = idx_s1;
						wr_pay            = rd_pay_s1;
						rsp_d.hit         = 1'b1;
						rsp_d.slot_index  = lkc_pkg::SLOT_W'(idx_s1);
						rsp_d.payload_out = lkc_pkg::OUT_PAY_W'(rd_pay_s1);
					end else begin
						rsp_d.slot_index  = lkc_pkg::SLOT_W'(miss_slot);
						rsp_d.payload_out = lkc_pkg::OUT_PAY_W'(pay_q);
						if (full) begin
							rsp_d.evicted         = 1'b1;
							rsp_d.evicted_payload = lkc_pkg::OUT_PAY_W'(victim_pay);
						end else begin
							fill_d = fill_q + CNT_W'(1);
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lkc_pkg::ST_IDLE;
			fill_q      <= '0;
			use_clock_q <= '0;
			rd_cnt_q    <= '0;
			valid_s1    <= 1'b0;
			done        <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			use_clock_q <= use_clock_d;
			valid_s1    <= issue;
			done        <= done_d;
			if (accept) begin
				rd_cnt_q <= '0;
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= rd_addr;
		last_s1 <= (rd_cnt_q == fill_q - CNT_W'(1));
		result  <= rsp_d;
		if (accept) begin
			key_q <= in_key;
			pay_q <= in_pay;
		end
	end

endmodule

// ===== design/lru_keyed_cache_table_unit.sv =====
// A flush, or an access to an empty table, shows its result in the cycle after transfer.
// Other accesses scan filled entries in order, one per cycle through a registered read port;
// the result is registered once the hit or the last filled entry has been read and compared.
// Commands are taken one at a time: a new one is accepted only while busy is low.
// Reset: arst_n empties the table and clears the use clock; no clearing pass is needed.
// The receiver cannot stall: each result is valid for the single cycle that done is high.
module lru_keyed_cache_table_unit #(
	parameter int ENTRIES      = lkc_pkg::DEF_ENTRIES,
	parameter int KEY_BITS     = lkc_pkg::DEF_KEY_BITS,
	parameter int PAYLOAD_BITS = lkc_pkg::DEF_PAYLOAD_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lkc_pkg::cmd_t cmd,
	output logic          done,
	output lkc_pkg::rsp_t result
);

	// Payload storage never needs more bits than the command field carries.
	localparam int PAY_W = (PAYLOAD_BITS < lkc_pkg::IN_PAY_W) ? PAYLOAD_BITS : lkc_pkg::IN_PAY_W;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	logic [IDX_W-1:0]            rd_addr;
	logic                        wr_en;
	logic [IDX_W-1:0]            wr_addr;
	logic [KEY_BITS-1:0]         wr_key;
	logic [PAY_W-1:0]            wr_pay;
	logic [lkc_pkg::STAMP_W-1:0] wr_stamp;
	logic [KEY_BITS-1:0]         rd_key_s1;
	logic [PAY_W-1:0]            rd_pay_s1;
	logic [lkc_pkg::STAMP_W-1:0] rd_stamp_s1;
	logic                        valid_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic [KEY_BITS-1:0]         key_q;
	logic                        match;
	logic [IDX_W-1:0]            victim_idx;
	logic [PAY_W-1:0]            victim_pay;

	// Entry store: key, payload and use stamp, written once per command at most.
	lkc_table #(
		.ENTRIES (ENTRIES),
		.KEY_W   (KEY_BITS),
		.PAY_W   (PAY_W),
		.IDX_W   (IDX_W)
	) u_table (
		.clk         (clk),
		.rd_addr     (rd_addr),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_key      (wr_key),
		.wr_pay      (wr_pay),
		.wr_stamp    (wr_stamp),
		.rd_key_s1   (rd_key_s1),
		.rd_pay_s1   (rd_pay_s1),
		.rd_stamp_s1 (rd_stamp_s1)
	);

	// Shared compare unit: key match on each entry read, plus the running
	// oldest-stamp tracker that names the victim once the table is full.
	lkc_scan #(
		.KEY_W (KEY_BITS),
		.PAY_W (PAY_W),
		.IDX_W (IDX_W)
	) u_scan (
		.clk         (clk),
		.valid_s1    (valid_s1),
		.idx_s1      (idx_s1),
		.key_ref     (key_q),
		.rd_key_s1   (rd_key_s1),
		.rd_pay_s1   (rd_pay_s1),
		.rd_stamp_s1 (rd_stamp_s1),
		.match       (match),
		.victim_idx  (victim_idx),
		.victim_pay  (victim_pay)
	);

	// Sequencer: a flush empties the table; an access walks the filled entries,
	// stops on the first match or after the last one, then writes the entry,
	// advances the use clock and drives the result for one cycle.
	lkc_seq #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS),
		.PAY_W    (PAY_W),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.done       (done),
		.result     (result),
		.rd_addr    (rd_addr),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_key     (wr_key),
		.wr_pay     (wr_pay),
		.wr_stamp   (wr_stamp),
		.valid_s1   (valid_s1),
		.idx_s1     (idx_s1),
		.key_q      (key_q),
		.rd_pay_s1  (rd_pay_s1),
		.match      (match),
		.victim_idx (victim_idx),
		.victim_pay (victim_pay)
	);

endmodule
